// ===== rtl/ppz_pkg.sv =====
// Shared types, codes and constants of the point projection depth buffer.
`timescale 1ns / 1ps

package ppz_pkg;

    localparam int DEF_MAX_WIDTH  = 640;
    localparam int DEF_MAX_HEIGHT = 480;
    localparam int DEF_INDEX_BITS = 20;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_READ   = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_STORED     = 3'd0,
        ST_OCCLUDED   = 3'd1,
        ST_NOT_FINITE = 3'd2,
        ST_ZERO_DEPTH = 3'd3,
        ST_OUTSIDE    = 3'd4,
        ST_READ_DATA  = 3'd5,
        ST_CLEARED    = 3'd6
    } status_t;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_X      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOCAL_Y      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y     = 3'd5;

    localparam logic [9:0]  RST_IMAGE_WIDTH  = 10'd640;
    localparam logic [8:0]  RST_IMAGE_HEIGHT = 9'd480;
    localparam logic [19:0] RST_FOCAL        = 20'd134400;
    localparam logic [19:0] RST_CENTER_X     = 20'd81792;
    localparam logic [19:0] RST_CENTER_Y     = 20'd61312;

    // Metres (Q16.16) to millimetres scale factor.
    localparam logic signed [20:0] MM_PER_M = 21'sd1000;

endpackage

// ===== rtl/ppz_if.sv =====
// Channel interfaces: command beats in, result beats out, register writes.
`timescale 1ns / 1ps

interface ppz_cmd_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;
    logic signed [31:0] z_coord;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic               point_finite;
    logic [19:0]        point_index;
    logic [9:0]         read_column;
    logic [8:0]         read_row;

    modport source (output valid, opcode, x_coord, y_coord, z_coord, red_in, green_in,
                    blue_in, point_finite, point_index, read_column, read_row,
                    input ready);
    modport sink (input valid, opcode, x_coord, y_coord, z_coord, red_in, green_in,
                  blue_in, point_finite, point_index, read_column, read_row,
                  output ready);
endinterface

interface ppz_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [9:0]  pixel_column;
    logic [8:0]  pixel_row;
    logic [15:0] depth_mm;
    logic [7:0]  red_out;
    logic [7:0]  green_out;
    logic [7:0]  blue_out;
    logic [19:0] index_out;

    modport source (output valid, status, pixel_column, pixel_row, depth_mm, red_out,
                    green_out, blue_out, index_out, input ready);
    modport sink (input valid, status, pixel_column, pixel_row, depth_mm, red_out,
                  green_out, blue_out, index_out, output ready);
endinterface

interface ppz_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ppz_pkg::CFG_IDX_W-1:0] reg_index;
    logic [ppz_pkg::CFG_DAT_W-1:0] wdata;

    modport source (output valid, reg_index, wdata, input ready);
    modport sink (input valid, reg_index, wdata, output ready);
endinterface

// ===== rtl/point_projection_zbuffer.sv =====
// Top level: pinhole projection of colored points into a nearest-point depth buffer.
`timescale 1ns / 1ps

//  Channel  Dir  Beat contents
//  cmd      in   opcode, x/y/z Q16.16, color, finite flag, point index, read pixel
//  result   out  status, pixel column/row, depth in mm, color, stored point index
//  cfg      in   register index and write data (always ready)
//
//  A stored or occluded insert runs S_DEPTH (z*1000) and S_CHECK (depth checks), then per
//  axis S_MA, S_MB, S_NUM, S_PREP, S_DIV, S_AXEND on one shared 32x21 multiplier and one
//  restoring divider (one quotient bit per cycle, 10 bits per axis by default), then
//  S_ADDR, S_RD, S_UPD, S_DONE for memory access and result. A read runs S_ADDR to S_DONE; a
//  read outside the frame, or a rejected insert, goes to S_DONE from S_IDLE, S_CHECK or S_AXEND.
//  A clear and the reset pass sweep memory one entry per cycle; a held result stalls cmd until it loads.

module point_projection_zbuffer #(
    parameter int MAX_WIDTH  = ppz_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = ppz_pkg::DEF_MAX_HEIGHT,
    parameter int INDEX_BITS = ppz_pkg::DEF_INDEX_BITS
) (
    input logic           clk,
    input logic           rst_n,
    ppz_cmd_if.sink       cmd,
    ppz_result_if.source  result,
    ppz_cfg_if.sink       cfg
);

    localparam int NPIX    = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW      = $clog2(NPIX);
    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RW      = $clog2(MAX_HEIGHT);
    localparam int MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    // Quotient bits: any coordinate at or above 2**QB lies outside the frame.
    localparam int QB      = $clog2(MAX_DIM);
    localparam int QCW     = $clog2(QB);
    localparam int MW      = 16 + 24 + INDEX_BITS;

    // One-hot sequencer states.
    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_CLR   = 14'b00000000000010,
        S_DEPTH = 14'b00000000000100,
        S_CHECK = 14'b00000000001000,
        S_MA    = 14'b00000000010000,
        S_MB    = 14'b00000000100000,
        S_NUM   = 14'b00000001000000,
        S_PREP  = 14'b00000010000000,
        S_DIV   = 14'b00000100000000,
        S_AXEND = 14'b00001000000000,
        S_ADDR  = 14'b00010000000000,
        S_RD    = 14'b00100000000000,
        S_UPD   = 14'b01000000000000,
        S_DONE  = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [9:0]  width_reg;
    logic [8:0]  height_reg;
    logic [19:0] fx_reg, fy_reg, cx_reg, cy_reg;

    // Latched command.
    logic [1:0]            op_reg, op_next;
    logic signed [31:0]    x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [23:0]           color_reg, color_next;
    logic [INDEX_BITS-1:0] idx_reg, idx_next;
    logic                  finite_reg, finite_next;

    // Datapath.
    logic signed [52:0] prod_reg, prod_next;
    logic signed [53:0] acc_reg, acc_next;
    logic [15:0]        depth_reg, depth_next;
    logic               axis_reg, axis_next;
    logic               neg_reg, neg_next;
    logic               ovf_reg, ovf_next;
    logic [63:0]        rem_reg, rem_next, dsh_reg, dsh_next;
    logic [QB-1:0]      q_reg, q_next;
    logic [QCW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [AW-1:0]      addr_reg, addr_next;
    logic [AW-1:0]      clr_cnt_reg, clr_cnt_next;
    logic               clr_rep_reg, clr_rep_next;

    // Pending result and output register.
    logic [2:0]            r_status_reg, r_status_next;
    logic [9:0]            r_col_reg, r_col_next;
    logic [8:0]            r_row_reg, r_row_next;
    logic [15:0]           r_depth_reg, r_depth_next;
    logic [23:0]           r_color_reg, r_color_next;
    logic [INDEX_BITS-1:0] r_idx_reg, r_idx_next;
    logic                  o_valid_reg, o_valid_next;
    logic [2:0]            o_status_reg, o_status_next;
    logic [9:0]            o_col_reg, o_col_next;
    logic [8:0]            o_row_reg, o_row_next;
    logic [15:0]           o_depth_reg, o_depth_next;
    logic [23:0]           o_color_reg, o_color_next;
    logic [19:0]           o_idx_reg, o_idx_next;

    // Frame memory: {depth, red:green:blue, point index}.
    logic [MW-1:0] mem [NPIX];
    logic [MW-1:0] rd_word_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr;
    logic [MW-1:0] mem_wdata;

    // Shared multiplier.
    logic signed [31:0] mul_a;
    logic signed [20:0] mul_b;
    logic signed [52:0] mul_p;

    logic [31:0] w_act, h_act, lim;
    logic [36:0] depth_raw;
    logic [53:0] abs_num;
    logic [39:0] den;
    logic        ge;
    logic        axis_in;
    logic [15:0] sd;
    logic        cmd_acc, out_free;

    assign cmd_acc  = cmd.valid && cmd.ready;
    assign cmd.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign out_free = !o_valid_reg || result.ready;

    assign w_act = (32'(width_reg) < 32'(MAX_WIDTH)) ? 32'(width_reg) : 32'(MAX_WIDTH);
    assign h_act = (32'(height_reg) < 32'(MAX_HEIGHT)) ? 32'(height_reg) : 32'(MAX_HEIGHT);
    assign lim   = axis_reg ? h_act : w_act;

    assign mul_p = mul_a * mul_b;
    assign depth_raw = prod_reg[52:16];
    assign abs_num = acc_reg[53] ? 54'(-acc_reg) : 54'(acc_reg);
    assign den = {z_reg[31:0], 8'd0};
    assign ge = (rem_reg >= dsh_reg);
    assign sd = rd_word_reg[MW-1 -: 16];
    // A coordinate is inside when the quotient did not overflow, a negative value
    // lies above -1 so that it truncates to zero, and the truncated value is below
    // the active size (so a zero size rejects everything).
    assign axis_in = !ovf_reg && !(neg_reg && (q_reg != '0)) &&
                     (32'(q_reg) < lim);

    always_comb
    begin
        mul_a = z_reg;
        mul_b = ppz_pkg::MM_PER_M;
        unique case (state_reg)
            S_MA:
            begin
                mul_a = axis_reg ? y_reg : x_reg;
                mul_b = signed'({1'b0, (axis_reg ? fy_reg : fx_reg)});
            end
            S_MB:
            begin
                mul_a = z_reg;
                mul_b = signed'({1'b0, (axis_reg ? cy_reg : cx_reg)});
            end
            default:
            begin
                mul_a = z_reg;
                mul_b = ppz_pkg::MM_PER_M;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        color_next    = color_reg;
        idx_next      = idx_reg;
        finite_next   = finite_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        depth_next    = depth_reg;
        axis_next     = axis_reg;
        neg_next      = neg_reg;
        ovf_next      = ovf_reg;
        rem_next      = rem_reg;
        dsh_next      = dsh_reg;
        q_next        = q_reg;
        cnt_next      = cnt_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        addr_next     = addr_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_rep_next  = clr_rep_reg;
        r_status_next = r_status_reg;
        r_col_next    = r_col_reg;
        r_row_next    = r_row_reg;
        r_depth_next  = r_depth_reg;
        r_color_next  = r_color_reg;
        r_idx_next    = r_idx_reg;
        o_valid_next  = o_valid_reg && !result.ready;
        o_status_next = o_status_reg;
        o_col_next    = o_col_reg;
        o_row_next    = o_row_reg;
        o_depth_next  = o_depth_reg;
        o_color_next  = o_color_reg;
        o_idx_next    = o_idx_reg;
        mem_we        = 1'b0;
        mem_re        = 1'b0;
        mem_waddr     = clr_cnt_reg;
        mem_wdata     = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                r_col_next   = '0;
                r_row_next   = '0;
                r_depth_next = '0;
                r_color_next = '0;
                r_idx_next   = '0;
                if (cmd_acc)
                begin
                    op_next     = cmd.opcode;
                    x_next      = cmd.x_coord;
                    y_next      = cmd.y_coord;
                    z_next      = cmd.z_coord;
                    color_next  = {cmd.red_in, cmd.green_in, cmd.blue_in};
                    idx_next    = INDEX_BITS'(cmd.point_index);
                    finite_next = cmd.point_finite;
                    unique case (cmd.opcode)
                        ppz_pkg::OP_CLEAR:
                        begin
                            clr_cnt_next = '0;
                            clr_rep_next = 1'b1;
                            state_next   = S_CLR;
                        end
                        ppz_pkg::OP_INSERT:
                        begin
                            state_next = S_DEPTH;
                        end
                        ppz_pkg::OP_READ:
                        begin
                            if ((32'(cmd.read_column) >= w_act) ||
                                (32'(cmd.read_row) >= h_act))
                            begin
                                r_status_next = ppz_pkg::ST_OUTSIDE;
                                state_next    = S_DONE;
                            end
                            else
                            begin
                                col_next   = CW'(cmd.read_column);
                                row_next   = RW'(cmd.read_row);
                                state_next = S_ADDR;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_CLR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(NPIX - 1))
                begin
                    r_status_next = ppz_pkg::ST_CLEARED;
                    state_next    = clr_rep_reg ? S_DONE : S_IDLE;
                end
            end

            S_DEPTH:
            begin
                prod_next  = mul_p;
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                depth_next = (depth_raw[36:16] != '0) ? 16'hFFFF : depth_raw[15:0];
                axis_next  = 1'b0;
                if (!finite_reg)
                begin
                    r_status_next = ppz_pkg::ST_NOT_FINITE;
                    state_next    = S_DONE;
                end
                else if (z_reg <= 0 || depth_raw == '0)
                begin
                    r_status_next = ppz_pkg::ST_ZERO_DEPTH;
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_MA;
                end
            end

            S_MA:
            begin
                prod_next  = mul_p;
                state_next = S_MB;
            end

            S_MB:
            begin
                acc_next   = 54'(prod_reg);
                prod_next  = mul_p;
                state_next = S_NUM;
            end

            S_NUM:
            begin
                acc_next   = acc_reg + 54'(prod_reg);
                state_next = S_PREP;
            end

            S_PREP:
            begin
                neg_next   = acc_reg[53];
                ovf_next   = (64'(abs_num) >= (64'(den) << QB));
                rem_next   = 64'(abs_num);
                dsh_next   = 64'(den) << (QB - 1);
                q_next     = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end

            S_DIV:
            begin
                if (ge)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                dsh_next = dsh_reg >> 1;
                q_next   = {q_reg[QB-2:0], ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == QCW'(QB - 1))
                begin
                    state_next = S_AXEND;
                end
            end

            S_AXEND:
            begin
                if (!axis_in)
                begin
                    r_status_next = ppz_pkg::ST_OUTSIDE;
                    state_next    = S_DONE;
                end
                else if (!axis_reg)
                begin
                    col_next   = neg_reg ? '0 : CW'(q_reg);
                    axis_next  = 1'b1;
                    state_next = S_MA;
                end
                else
                begin
                    row_next   = neg_reg ? '0 : RW'(q_reg);
                    state_next = S_ADDR;
                end
            end

            S_ADDR:
            begin
                addr_next  = AW'(32'(row_reg) * MAX_WIDTH + 32'(col_reg));
                state_next = S_RD;
            end

            S_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_UPD;
            end

            S_UPD:
            begin
                r_col_next   = 10'(col_reg);
                r_row_next   = 9'(row_reg);
                r_depth_next = sd;
                r_color_next = rd_word_reg[INDEX_BITS +: 24];
                r_idx_next   = rd_word_reg[INDEX_BITS-1:0];
                if (op_reg == ppz_pkg::OP_READ)
                begin
                    r_status_next = ppz_pkg::ST_READ_DATA;
                end
                else if (sd == '0 || depth_reg < sd)
                begin
                    // Strictly nearer (or empty pixel): the new point replaces it.
                    mem_we        = 1'b1;
                    mem_waddr     = addr_reg;
                    mem_wdata     = {depth_reg, color_reg, idx_reg};
                    r_status_next = ppz_pkg::ST_STORED;
                    r_depth_next  = depth_reg;
                    r_color_next  = color_reg;
                    r_idx_next    = idx_reg;
                end
                else
                begin
                    r_status_next = ppz_pkg::ST_OCCLUDED;
                end
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    o_valid_next  = 1'b1;
                    o_status_next = r_status_reg;
                    o_col_next    = r_col_reg;
                    o_row_next    = r_row_reg;
                    o_depth_next  = r_depth_reg;
                    o_color_next  = r_color_reg;
                    o_idx_next    = 20'(r_idx_reg);
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_word_reg <= mem[addr_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            clr_rep_reg <= 1'b0;
            o_valid_reg <= 1'b0;
            width_reg   <= ppz_pkg::RST_IMAGE_WIDTH;
            height_reg  <= ppz_pkg::RST_IMAGE_HEIGHT;
            fx_reg      <= ppz_pkg::RST_FOCAL;
            fy_reg      <= ppz_pkg::RST_FOCAL;
            cx_reg      <= ppz_pkg::RST_CENTER_X;
            cy_reg      <= ppz_pkg::RST_CENTER_Y;
            axis_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            clr_rep_reg <= clr_rep_next;
            o_valid_reg <= o_valid_next;
            axis_reg    <= axis_next;
            cnt_reg     <= cnt_next;
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.reg_index)
                    ppz_pkg::REG_IMAGE_WIDTH:  width_reg  <= cfg.wdata[9:0];
                    ppz_pkg::REG_IMAGE_HEIGHT: height_reg <= cfg.wdata[8:0];
                    ppz_pkg::REG_FOCAL_X:      fx_reg     <= cfg.wdata;
                    ppz_pkg::REG_FOCAL_Y:      fy_reg     <= cfg.wdata;
                    ppz_pkg::REG_CENTER_X:     cx_reg     <= cfg.wdata;
                    ppz_pkg::REG_CENTER_Y:     cy_reg     <= cfg.wdata;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        color_reg    <= color_next;
        idx_reg      <= idx_next;
        finite_reg   <= finite_next;
        prod_reg     <= prod_next;
        acc_reg      <= acc_next;
        depth_reg    <= depth_next;
        neg_reg      <= neg_next;
        ovf_reg      <= ovf_next;
        rem_reg      <= rem_next;
        dsh_reg      <= dsh_next;
        q_reg        <= q_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        addr_reg     <= addr_next;
        r_status_reg <= r_status_next;
        r_col_reg    <= r_col_next;
        r_row_reg    <= r_row_next;
        r_depth_reg  <= r_depth_next;
        r_color_reg  <= r_color_next;
        r_idx_reg    <= r_idx_next;
        o_status_reg <= o_status_next;
        o_col_reg    <= o_col_next;
        o_row_reg    <= o_row_next;
        o_depth_reg  <= o_depth_next;
        o_color_reg  <= o_color_next;
        o_idx_reg    <= o_idx_next;
    end

    assign result.valid        = o_valid_reg;
    assign result.status       = o_status_reg;
    assign result.pixel_column = o_col_reg;
    assign result.pixel_row    = o_row_reg;
    assign result.depth_mm     = o_depth_reg;
    assign result.red_out      = o_color_reg[23:16];
    assign result.green_out    = o_color_reg[15:8];
    assign result.blue_out     = o_color_reg[7:0];
    assign result.index_out    = o_idx_reg;

    // An accepted insert always starts with the depth product.
    a_insert_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_acc && cmd.opcode == ppz_pkg::OP_INSERT |=> state_reg == S_DEPTH)
        else $error("insert did not start the depth product");

    // The divider never runs past its last quotient bit.
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg <= QCW'(QB - 1))
        else $error("divider step count out of range");

    // The frame memory is written only by the sweep or by a winning insert.
    a_mem_write: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLR || state_reg == S_UPD))
        else $error("unexpected frame memory write");

    // A stored point always carries a nonzero depth.
    a_stored_depth: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.status == ppz_pkg::ST_STORED |-> result.depth_mm != 16'd0)
        else $error("stored result with zero depth");

endmodule
